>>> hdl/spike_exponential_feature_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// Spike history encoder assertion macros
// Concurrent checks clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SPIKE_EXPONENTIAL_FEATURE_ENCODER_CORE_ASSERT_SVH
`define SPIKE_EXPONENTIAL_FEATURE_ENCODER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every edge out of reset
`define SEFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// condition must never be seen out of reset
`define SEFE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define SEFE_ASSERT(lbl, prop, msg)
`define SEFE_NEVER(lbl, cond, msg)
`endif

`endif

>>> hdl/sefe_pkg.sv
// ----------------------------------------------------------------------------
// Spike history encoder package
// Types and fixed constants shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sefe_pkg;

    localparam int WEIGHT_W   = 17;
    localparam int FACTOR_W   = 16;
    localparam int MASK_W     = 8;
    localparam int BIN_W      = 31;
    localparam int CH_OUT_W   = 3;
    localparam int SL_OUT_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;
    localparam int M_USER_W   = 2;

    localparam logic [WEIGHT_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [FACTOR_W-1:0] DECAY_RESET = 16'd62119;
    localparam logic [MASK_W-1:0]   REQ_RESET   = 8'hFF;
    localparam logic [15:0]         ROUND_HALF  = 16'h8000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_MASK = 2'd1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SWEEP
    } sefe_state_t;

endpackage

`default_nettype wire

>>> hdl/sefe_cell.sv
// ----------------------------------------------------------------------------
// Spike history weight cell
// One stored slot weight; takes its neighbour's value on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sefe_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          shift_en,
    input  wire logic [sefe_pkg::WEIGHT_W-1:0] weight_in,
    output logic      [sefe_pkg::WEIGHT_W-1:0] weight_out
);

    logic [sefe_pkg::WEIGHT_W-1:0] weight_reg;
    logic [sefe_pkg::WEIGHT_W-1:0] weight_next;

    always_comb begin
        weight_next = shift_en ? weight_in : weight_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
        end else begin
            weight_reg <= weight_next;
        end
    end

    assign weight_out = weight_reg;

endmodule

`default_nettype wire

>>> hdl/sefe_decay.sv
// ----------------------------------------------------------------------------
// Spike history decay unit
// Multiplies a Q1.16 weight by the decay factor with round-half-up.
// ----------------------------------------------------------------------------
`default_nettype none

module sefe_decay (
    input  wire logic [sefe_pkg::WEIGHT_W-1:0] weight_in,
    input  wire logic [sefe_pkg::FACTOR_W-1:0] factor_in,
    output logic      [sefe_pkg::WEIGHT_W-1:0] weight_out
);

    localparam int PROD_W = sefe_pkg::WEIGHT_W + sefe_pkg::FACTOR_W;

    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] rounded;

    // largest product stays below 2^32, so the rounding add cannot carry out
    always_comb begin
        product    = PROD_W'(weight_in) * PROD_W'(factor_in);
        rounded    = product + PROD_W'(sefe_pkg::ROUND_HALF);
        weight_out = rounded[sefe_pkg::FACTOR_W +: sefe_pkg::WEIGHT_W];
    end

endmodule

`default_nettype wire

>>> hdl/spike_exponential_feature_encoder_core.sv
// ----------------------------------------------------------------------------
// Spike history exponential feature encoder
// Keeps decayed weights of the last SLOTS spikes per channel in a ring of
// cells and emits CHANNELS*SLOTS features per bin once required channels warm.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  s_       | in  | s_tvalid / s_tready | s_tdata: spike_mask, time_bin
//  m_       | out | m_tvalid / m_tready | m_tdata, m_tuser flags, m_tlast
//  cfg_     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A good bin is accepted, then the ring rotates once, one slot per step,
// past the single shared decay multiplier.
// A bin with a broken number leaves the state alone.
// In a ready bin the ring stalls while the output register is full and not taken.
// aresetn is synchronous; it clears all weights, counts and warm flags.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_exponential_feature_encoder_core #(
    parameter int CHANNELS = 8,
    parameter int SLOTS    = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // [7:0] spike_mask, [38:8] time_bin, [39] zero
    input  wire logic [sefe_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [16:0] feature_value, [19:17] channel_index, [21:20] slot_index, [23:22] zero
    output logic      [sefe_pkg::M_DATA_W-1:0]   m_tdata,
    // [0] ready_res, [1] bin_error
    output logic      [sefe_pkg::M_USER_W-1:0]   m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sefe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sefe_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "spike_exponential_feature_encoder_core_assert.svh"

    localparam int NCELLS   = CHANNELS * SLOTS;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SL_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int NEXT_IDX = (NCELLS > 1) ? 1 : 0;
    localparam int W_W      = sefe_pkg::WEIGHT_W;

    // registers
    sefe_pkg::sefe_state_t            state_reg, state_next;
    logic [sefe_pkg::FACTOR_W-1:0]    decay_reg;
    logic [sefe_pkg::MASK_W-1:0]      req_reg;
    logic [sefe_pkg::BIN_W-1:0]       prev_bin_reg;
    logic [CHANNELS-1:0]              spk_reg;
    logic [CHANNELS-1:0]              warm_reg;
    logic [CNT_W-1:0]                 cnt_reg [CHANNELS];
    logic                             ready_reg;
    logic [CH_W-1:0]                  ch_reg;
    logic [SL_W-1:0]                  sl_reg;
    logic                             m_valid_reg;
    logic [W_W-1:0]                   m_feat_reg;
    logic [sefe_pkg::CH_OUT_W-1:0]    m_ch_reg;
    logic [sefe_pkg::SL_OUT_W-1:0]    m_sl_reg;
    logic                             m_rdy_reg;
    logic                             m_err_reg;
    logic                             m_last_reg;

    // combinational
    logic [sefe_pkg::MASK_W-1:0]      in_mask;
    logic [sefe_pkg::BIN_W-1:0]       in_bin;
    logic [sefe_pkg::BIN_W-1:0]       exp_bin;
    logic                             bin_bad;
    logic [CHANNELS-1:0]              spk_vec;
    logic [CHANNELS-1:0]              req_vec;
    logic [CHANNELS-1:0]              warm_new;
    logic                             ready_new;
    logic                             out_free;
    logic                             s_acc;
    logic                             step;
    logic                             last_elem;
    logic                             slot_end;
    logic [CNT_W-1:0]                 cur_cnt;
    logic                             filling;
    logic                             cur_spk;
    logic                             put_one;
    logic [W_W-1:0]                   dec_in;
    logic [W_W-1:0]                   dec_out;
    logic [W_W-1:0]                   w_new;
    logic [W_W-1:0]                   cell_q [NCELLS];
    logic                             in_sweep;
    logic                             bad_req;
    logic                             err_out;

    assign in_mask = s_tdata[sefe_pkg::MASK_W-1:0];
    assign in_bin  = s_tdata[sefe_pkg::MASK_W +: sefe_pkg::BIN_W];
    assign exp_bin = prev_bin_reg + sefe_pkg::BIN_W'(1);
    assign bin_bad = (in_bin == '0) || (in_bin != exp_bin);

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_chan
            if (c < sefe_pkg::MASK_W) begin : g_real
                assign spk_vec[c] = in_mask[c];
                assign req_vec[c] = req_reg[c];
            end else begin : g_absent
                assign spk_vec[c] = 1'b0;
                assign req_vec[c] = 1'b0;
            end
            assign warm_new[c] = warm_reg[c] | (cnt_reg[c] == CNT_W'(SLOTS));
        end
    endgenerate

    assign ready_new = &(warm_new | ~req_vec);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_acc     = s_tvalid && s_tready;
    assign slot_end  = (sl_reg == SL_W'(SLOTS - 1));
    assign last_elem = slot_end && (ch_reg == CH_W'(CHANNELS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sefe_pkg::ST_IDLE: begin
                if (s_acc && !bin_bad) begin
                    state_next = sefe_pkg::ST_SWEEP;
                end
            end
            sefe_pkg::ST_SWEEP: begin
                if (step && last_elem) begin
                    state_next = sefe_pkg::ST_IDLE;
                end
            end
            default: state_next = sefe_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        step     = 1'b0;
        unique case (state_reg)
            sefe_pkg::ST_IDLE:  s_tready = out_free;
            sefe_pkg::ST_SWEEP: step     = !ready_reg || out_free;
            default: begin
                s_tready = 1'b0;
                step     = 1'b0;
            end
        endcase
    end

    // slot update at the head of the ring
    always_comb begin
        cur_cnt = cnt_reg[ch_reg];
        filling = cur_cnt < CNT_W'(SLOTS);
        cur_spk = spk_reg[ch_reg];
        // full channel with a spike: slots move down, so take the next cell
        dec_in  = (cur_spk && !filling) ? cell_q[NEXT_IDX] : cell_q[0];
        put_one = cur_spk && (filling ? (CNT_W'(sl_reg) == cur_cnt) : slot_end);
        w_new   = put_one ? sefe_pkg::ONE_Q16 : dec_out;
    end

    sefe_decay u_decay (
        .weight_in  (dec_in),
        .factor_in  (decay_reg),
        .weight_out (dec_out)
    );

    genvar i;
    generate
        for (i = 0; i < NCELLS; i++) begin : g_cell
            logic [W_W-1:0] cell_in;
            if (i == NCELLS - 1) begin : g_tail
                assign cell_in = w_new;
            end else begin : g_body
                assign cell_in = cell_q[i + 1];
            end
            sefe_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (step),
                .weight_in  (cell_in),
                .weight_out (cell_q[i])
            );
        end
    endgenerate

    assign cfg_ready = 1'b1;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sefe_pkg::ST_IDLE;
            decay_reg    <= sefe_pkg::DECAY_RESET;
            req_reg      <= sefe_pkg::REQ_RESET;
            prev_bin_reg <= '0;
            warm_reg     <= '0;
            ready_reg    <= 1'b0;
            ch_reg       <= '0;
            sl_reg       <= '0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    sefe_pkg::CFG_DECAY_FACTOR:  decay_reg <= cfg_data;
                    sefe_pkg::CFG_REQUIRED_MASK: req_reg   <= cfg_data[sefe_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end
            if (s_acc) begin
                // a broken or cold bin answers at once with its single result
                m_valid_reg <= bin_bad || !ready_new;
                if (!bin_bad) begin
                    prev_bin_reg <= in_bin;
                    warm_reg     <= warm_new;
                    ready_reg    <= ready_new;
                    ch_reg       <= '0;
                    sl_reg       <= '0;
                end
            end else if (step && ready_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (step) begin
                if (slot_end) begin
                    sl_reg <= '0;
                    ch_reg <= ch_reg + CH_W'(1);
                    if (cur_spk && filling) begin
                        cnt_reg[ch_reg] <= cur_cnt + CNT_W'(1);
                    end
                end else begin
                    sl_reg <= sl_reg + SL_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            spk_reg    <= spk_vec;
            m_feat_reg <= '0;
            m_ch_reg   <= '0;
            m_sl_reg   <= '0;
            m_rdy_reg  <= 1'b0;
            m_err_reg  <= bin_bad;
            m_last_reg <= 1'b1;
        end else if (step && ready_reg) begin
            m_feat_reg <= warm_reg[ch_reg] ? w_new : '0;
            m_ch_reg   <= sefe_pkg::CH_OUT_W'(ch_reg);
            m_sl_reg   <= sefe_pkg::SL_OUT_W'(sl_reg);
            m_rdy_reg  <= 1'b1;
            m_err_reg  <= 1'b0;
            m_last_reg <= last_elem;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_sl_reg, m_ch_reg, m_feat_reg};
    assign m_tuser  = {m_err_reg, m_rdy_reg};
    assign m_tlast  = m_last_reg;

    assign in_sweep = (state_reg == sefe_pkg::ST_SWEEP);
    assign bad_req  = s_acc && bin_bad;
    assign err_out  = m_tvalid && m_tuser[1] && m_tlast;

    `SEFE_NEVER(a_no_accept_in_sweep, in_sweep && s_tready, "request accepted during sweep")
    `SEFE_ASSERT(a_bad_bin_reports, bad_req |=> !in_sweep && err_out, "broken bin not reported")
    `SEFE_ASSERT(a_sweep_ends, (step && last_elem) |=> !in_sweep, "sweep overran final slot")
    `SEFE_NEVER(a_warm_sticky, ($past(warm_reg) & ~warm_reg) != '0, "warm flag dropped")

endmodule

`default_nettype wire

>>> bench/spike_exponential_feature_encoder_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike history encoder checker
// Watches the bin, feature and register channels. Keeps its own copy of the
// decayed slot weights, spike counts, warm flags and last bin number, works
// out the features that each accepted bin must produce and compares every
// feature that leaves the block, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module sefe_feature_checker #(
    parameter int CHANNELS = 8,
    parameter int SLOTS    = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [sefe_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sefe_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic [sefe_pkg::M_USER_W-1:0]   m_tuser,
    input  logic                            m_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sefe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sefe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatch_count,
    output int                              features_pending
);

    localparam int WEIGHT_W = sefe_pkg::WEIGHT_W;
    localparam int CH_OUT_W = sefe_pkg::CH_OUT_W;
    localparam int SL_OUT_W = sefe_pkg::SL_OUT_W;
    localparam int BIN_W    = sefe_pkg::BIN_W;
    localparam int FACTOR_W = sefe_pkg::FACTOR_W;
    localparam int MASK_W   = sefe_pkg::MASK_W;

    typedef struct packed {
        logic [WEIGHT_W-1:0] value;
        logic [CH_OUT_W-1:0] channel;
        logic [SL_OUT_W-1:0] slot;
        logic                ready;
        logic                bin_err;
        logic                last;
    } feature_t;

    logic [WEIGHT_W-1:0] weight [CHANNELS][SLOTS];
    int unsigned         spikes [CHANNELS];
    logic                warm [CHANNELS];
    logic [BIN_W-1:0]    last_bin;
    logic [FACTOR_W-1:0] decay_q16;
    logic [MASK_W-1:0]   required_channels;
    feature_t            feature_queue [$];
    int                  mismatches;

    initial begin
        mismatches = 0;
    end

    function automatic feature_t make_feature(input logic [WEIGHT_W-1:0] value,
                                              input int ch, input int sl,
                                              input logic rdy, input logic err,
                                              input logic lst);
        feature_t f;
        f.value   = value;
        f.channel = CH_OUT_W'(ch);
        f.slot    = SL_OUT_W'(sl);
        f.ready   = rdy;
        f.bin_err = err;
        f.last    = lst;
        return f;
    endfunction

    // append at the tail of the expected list
    function automatic void queue_feature(input feature_t f);
        feature_queue = {feature_queue, f};
    endfunction

    // advance the history by one bin and queue the features it yields
    task automatic encode_bin(input logic [MASK_W-1:0] mask,
                              input logic [BIN_W-1:0] bin);
        logic [63:0] prod;
        logic        all_warm;
        if (bin == '0 || bin != last_bin + 1'b1) begin
            queue_feature(make_feature('0, 0, 0, 1'b0, 1'b1, 1'b1));
            return;
        end
        last_bin = bin;
        for (int c = 0; c < CHANNELS; c++) begin
            if (spikes[c] >= SLOTS)
                warm[c] = 1'b1;
            for (int s = 0; s < SLOTS; s++) begin
                prod = 64'(weight[c][s]) * 64'(decay_q16) + 64'(sefe_pkg::ROUND_HALF);
                weight[c][s] = WEIGHT_W'(prod >> 16);
            end
            if (c < MASK_W && mask[c]) begin
                if (spikes[c] < SLOTS) begin
                    weight[c][spikes[c]] = sefe_pkg::ONE_Q16;
                    spikes[c]++;
                end else begin
                    // drop the oldest spike
                    for (int s = 0; s + 1 < SLOTS; s++)
                        weight[c][s] = weight[c][s+1];
                    weight[c][SLOTS-1] = sefe_pkg::ONE_Q16;
                end
            end
        end
        all_warm = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
            if (c < MASK_W && required_channels[c] && !warm[c])
                all_warm = 1'b0;
        if (!all_warm) begin
            queue_feature(make_feature('0, 0, 0, 1'b0, 1'b0, 1'b1));
            return;
        end
        for (int c = 0; c < CHANNELS; c++)
            for (int s = 0; s < SLOTS; s++)
                queue_feature(make_feature(warm[c] ? weight[c][s] : '0, c, s,
                    1'b1, 1'b0, (c == CHANNELS - 1) && (s == SLOTS - 1)));
    endtask

    task automatic check_feature(input feature_t got);
        feature_t want;
        if (feature_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected feature value=%0d ch=%0d slot=%0d %s%0b %s%0b %s%0b",
                         $time, got.value, got.channel, got.slot,
                         "rdy=", got.ready, "err=", got.bin_err, "last=", got.last);
            return;
        end
        want = feature_queue[0];
        feature_queue.delete(0);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: feature mismatch", $time);
                $display("  expected value=%0d ch=%0d slot=%0d rdy=%0b err=%0b last=%0b",
                         want.value, want.channel, want.slot, want.ready, want.bin_err,
                         want.last);
                $display("  actual   value=%0d ch=%0d slot=%0d rdy=%0b err=%0b last=%0b",
                         got.value, got.channel, got.slot, got.ready, got.bin_err,
                         got.last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int s = 0; s < SLOTS; s++)
                    weight[c][s] = '0;
                spikes[c] = 0;
                warm[c]   = 1'b0;
            end
            last_bin          = '0;
            decay_q16         = sefe_pkg::DECAY_RESET;
            required_channels = sefe_pkg::REQ_RESET;
            feature_queue.delete();
        end else begin
            // results first: a request accepted on this edge cannot have one yet
            if (m_tvalid && m_tready)
                check_feature(make_feature(m_tdata[0 +: WEIGHT_W],
                                           int'(m_tdata[WEIGHT_W +: CH_OUT_W]),
                                           int'(m_tdata[WEIGHT_W + CH_OUT_W +: SL_OUT_W]),
                                           m_tuser[0], m_tuser[1], m_tlast));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sefe_pkg::CFG_DECAY_FACTOR:  decay_q16 = cfg_data[FACTOR_W-1:0];
                    sefe_pkg::CFG_REQUIRED_MASK: required_channels = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                encode_bin(s_tdata[0 +: MASK_W], s_tdata[MASK_W +: BIN_W]);
        end
        mismatch_count   <= mismatches;
        features_pending <= feature_queue.size();
    end

endmodule

>>> bench/tb_spike_exponential_feature_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike history encoder testbench
// Sends directed and random time bins, with broken bin numbers mixed in,
// across several decay and required-channel settings. Bursty requests and a
// stalling result side exercise the handshakes; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_spike_exponential_feature_encoder_core;

    localparam int CHANNELS   = 8;
    localparam int SLOTS      = 4;
    localparam int S_DATA_W   = sefe_pkg::S_DATA_W;
    localparam int M_DATA_W   = sefe_pkg::M_DATA_W;
    localparam int M_USER_W   = sefe_pkg::M_USER_W;
    localparam int CFG_IDX_W  = sefe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sefe_pkg::CFG_DATA_W;
    localparam int BIN_W      = sefe_pkg::BIN_W;
    localparam int MASK_W     = sefe_pkg::MASK_W;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_pattern_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    mismatch_count;
    int                    features_pending;

    rx_pattern_t           rx_mode   = RX_ALWAYS;
    int                    rx_cycle  = 0;
    int                    rx_hold   = 0;
    bit                    quiet     = 1'b0;
    int                    burst_left = 1;
    logic [BIN_W-1:0]      next_bin  = 31'd1;

    always #5 aclk = ~aclk;

    spike_exponential_feature_encoder_core #(
        .CHANNELS (CHANNELS),
        .SLOTS    (SLOTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sefe_feature_checker #(
        .CHANNELS (CHANNELS),
        .SLOTS    (SLOTS)
    ) u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tdata          (s_tdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .features_pending (features_pending)
    );

    // result-side back-pressure
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= (rx_cycle % 7) < 4;
            default: begin
                if (rx_hold > 0) begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold  <= $urandom_range(5, 20);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    task automatic send_bin(input logic [MASK_W-1:0] mask, input logic [BIN_W-1:0] bin);
        int gap;
        s_tdata  <= {1'b0, bin, mask};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
    endtask

    task automatic send_good(input logic [MASK_W-1:0] mask);
        send_bin(mask, next_bin);
        next_bin++;
    endtask

    task automatic send_broken(input logic [MASK_W-1:0] mask);
        logic [BIN_W-1:0] bin;
        case ($urandom_range(0, 3))
            0:       bin = '0;
            1:       bin = next_bin - 1'b1;
            2:       bin = next_bin + BIN_W'($urandom_range(1, 4));
            default: bin = BIN_W'($urandom);
        endcase
        if (bin == next_bin)
            bin = bin ^ 31'h1;
        send_bin(mask, bin);
    endtask

    // hold off until every queued feature has come out and the core is idle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (features_pending != 0)
            @(posedge aclk);
        repeat (CHANNELS * SLOTS + 8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return MASK_W'(1 << $urandom_range(0, 7));
            default: return MASK_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] decay;
        logic [MASK_W-1:0]     required;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: zero and topmost bin numbers, a repeat, fill channels 0-3
        rx_mode = RX_RANDOM;
        send_bin(8'hFF, 31'd0);
        send_bin(8'h00, 31'h7FFF_FFFF);
        send_good(8'h0F);
        send_good(8'h1F);
        send_bin(8'h0F, next_bin - 1'b1);
        send_good(8'h3F);
        send_good(8'h0F);
        send_good(8'h80);
        wait_drained();

        // slowest decay, only the warm half required: cold channels read zero
        write_reg(sefe_pkg::CFG_DECAY_FACTOR, 16'hFFFF);
        write_reg(sefe_pkg::CFG_REQUIRED_MASK, 16'h000F);
        rx_mode = RX_ALWAYS;
        quiet   = 1'b1;
        send_good(8'h00);
        send_good(8'hFF);
        send_good(8'hAA);
        send_good(8'h55);
        send_good(8'h01);
        wait_drained();

        // zero decay wipes every weight; nothing required
        write_reg(sefe_pkg::CFG_DECAY_FACTOR, 16'h0000);
        write_reg(sefe_pkg::CFG_REQUIRED_MASK, 16'h0000);
        rx_mode = RX_LONG;
        quiet   = 1'b0;
        send_good(8'h80);
        send_good(8'h00);
        wait_drained();

        write_reg(sefe_pkg::CFG_DECAY_FACTOR, 16'h0001);
        write_reg(sefe_pkg::CFG_REQUIRED_MASK, 16'h00F0);
        rx_mode = RX_PERIODIC;
        send_good(8'hFF);
        send_good(8'h00);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 5))
                0:       decay = 16'hFFFF;
                1:       decay = 16'h0001;
                2:       decay = CFG_DATA_W'($urandom_range(60000, 65535));
                default: decay = CFG_DATA_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       required = 8'hFF;
                1:       required = 8'h00;
                default: required = MASK_W'($urandom);
            endcase
            write_reg(sefe_pkg::CFG_DECAY_FACTOR, decay);
            write_reg(sefe_pkg::CFG_REQUIRED_MASK,
                      {{(CFG_DATA_W - MASK_W){1'b0}}, required});
            rx_mode = rx_pattern_t'(phase % 4);
            quiet   = (phase % 3 == 0);
            for (int k = 0; k < 20; k++) begin
                if ($urandom_range(0, 99) < 15)
                    send_broken(random_mask());
                else
                    send_good(random_mask());
            end
            wait_drained();
        end

        if (mismatch_count == 0 && features_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
